@@ rtl/core/eq_pkg.sv @@
package eq_pkg;

    localparam int IN_W         = 15;
    localparam int IN_DATA_W    = 48;
    localparam int ANG_LIMIT    = 12868;
    localparam int CORDIC_STEPS = 30;
    localparam int CW           = 34;
    localparam int Z_SHIFT      = 17;
    localparam int CORDIC_FRAC  = 30;

    typedef logic signed [IN_W-1:0] angle_t;
    typedef logic signed [CW-1:0]   cordic_t;

    localparam cordic_t CORDIC_GAIN = 34'sd652032874;

    localparam cordic_t ATAN_TABLE [CORDIC_STEPS] = '{
        34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158,
        34'sd67021686,  34'sd33543515,  34'sd16775850,  34'sd8388437,
        34'sd4194282,   34'sd2097149,   34'sd1048575,   34'sd524287,
        34'sd262143,    34'sd131071,    34'sd65535,     34'sd32767,
        34'sd16383,     34'sd8191,      34'sd4095,      34'sd2047,
        34'sd1023,      34'sd511,       34'sd255,       34'sd127,
        34'sd63,        34'sd31,        34'sd15,        34'sd7,
        34'sd3,         34'sd1
    };

endpackage

@@ rtl/core/euler_to_quaternion_core.sv @@
// ZYX Euler angles (yaw, pitch, roll; signed Q2.12 radians, saturated to +-pi)
// to unit quaternion w, x, y, z in signed Q1.(OUT_WIDTH-2). Fully pipelined:
// one request per clock while s_tready is high. The pipeline is made of the
// three 30-stage CORDIC pipelines (one per angle, plus entry and rounding
// stages) and the 5-stage product merge. A two-entry output register/skid
// pair absorbs back-pressure; s_tready drops only while the skid entry is
// occupied, which freezes the whole pipeline.
module euler_to_quaternion_core
    import eq_pkg::*;
#(
    parameter int ANGLE_WIDTH = 16,
    parameter int OUT_WIDTH   = 16
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [IN_DATA_W-1:0]                 s_tdata,  // yaw_angle, pitch_angle, roll_angle
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [((4*OUT_WIDTH+7)/8)*8-1:0]     m_tdata   // quat_w, quat_x, quat_y, quat_z
);

    localparam int LAT = CORDIC_STEPS + 2 + 5;
    localparam int OD  = 4 * OUT_WIDTH;
    localparam int ODP = ((4 * OUT_WIDTH + 7) / 8) * 8;

    logic en;
    logic [LAT-1:0] vld_reg;
    logic out_valid_reg, out_valid_next;
    logic skid_full_reg, skid_full_next;
    logic [OD-1:0] out_data_reg, out_data_next;
    logic [OD-1:0] skid_data_reg, skid_data_next;
    logic [OD-1:0] item;

    logic signed [ANGLE_WIDTH-1:0] cy, sy, cp, sp, cr, sr;
    logic signed [OUT_WIDTH-1:0]   qw, qx, qy, qz;

    assign en       = !skid_full_reg;
    assign s_tready = en;

    eq_lane #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_yaw
    (
        .clk     (clk),
        .en      (en),
        .angle   (angle_t'(s_tdata[IN_W-1:0])),
        .cos_val (cy),
        .sin_val (sy)
    );

    eq_lane #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_pitch
    (
        .clk     (clk),
        .en      (en),
        .angle   (angle_t'(s_tdata[2*IN_W-1:IN_W])),
        .cos_val (cp),
        .sin_val (sp)
    );

    eq_lane #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_roll
    (
        .clk     (clk),
        .en      (en),
        .angle   (angle_t'(s_tdata[3*IN_W-1:2*IN_W])),
        .cos_val (cr),
        .sin_val (sr)
    );

    eq_merge #(.ANGLE_WIDTH(ANGLE_WIDTH), .OUT_WIDTH(OUT_WIDTH)) u_merge
    (
        .clk    (clk),
        .en     (en),
        .cy     (cy),
        .sy     (sy),
        .cp     (cp),
        .sp     (sp),
        .cr     (cr),
        .sr     (sr),
        .quat_w (qw),
        .quat_x (qx),
        .quat_y (qy),
        .quat_z (qz)
    );

    assign item = {qz, qy, qx, qw};

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        skid_full_next = skid_full_reg;
        skid_data_next = skid_data_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (skid_full_reg && m_tready)
        begin
            out_valid_next = 1'b1;
            out_data_next  = skid_data_reg;
            skid_full_next = 1'b0;
        end
        if (en && vld_reg[LAT-1])
        begin
            if (!out_valid_reg || m_tready)
            begin
                out_valid_next = 1'b1;
                out_data_next  = item;
            end
            else
            begin
                skid_full_next = 1'b1;
                skid_data_next = item;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
            end
            out_valid_reg <= out_valid_next;
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = ODP'(out_data_reg);

`ifndef SYNTHESIS
    a_skid_needs_out : assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg |-> out_valid_reg)
        else $error("skid entry held without a pending output");

    a_skid_fill : assert property (@(posedge clk) disable iff (!rst_n)
        (en && vld_reg[LAT-1] && out_valid_reg && !m_tready) |=> skid_full_reg)
        else $error("result lost while output stalled");

    a_skid_cause : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_full_reg) |-> $past(vld_reg[LAT-1] && !m_tready))
        else $error("skid filled without a result leaving the pipeline");

    a_frozen : assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");
`endif

endmodule

@@ rtl/core/eq_lane.sv @@
module eq_lane
    import eq_pkg::*;
#(
    parameter int ANGLE_WIDTH = 16
)
(
    input  logic                          clk,
    input  logic                          en,
    input  angle_t                        angle,
    output logic signed [ANGLE_WIDTH-1:0] cos_val,
    output logic signed [ANGLE_WIDTH-1:0] sin_val
);

    localparam int TF  = ANGLE_WIDTH - 2;
    localparam int RSH = CORDIC_FRAC - TF;
    localparam cordic_t TRIG_ONE = CW'(1) <<< TF;

    cordic_t x_reg [CORDIC_STEPS+1];
    cordic_t y_reg [CORDIC_STEPS+1];
    cordic_t z_reg [CORDIC_STEPS+1];
    cordic_t x_rnd;
    cordic_t y_rnd;
    angle_t  ang_sat;
    logic signed [ANGLE_WIDTH-1:0] cos_reg;
    logic signed [ANGLE_WIDTH-1:0] sin_reg;

    function automatic cordic_t sat_one(input cordic_t v);
        cordic_t r;
        r = v;
        if (v > TRIG_ONE)
        begin
            r = TRIG_ONE;
        end
        else if (v < -TRIG_ONE)
        begin
            r = -TRIG_ONE;
        end
        return r;
    endfunction

    always_comb
    begin
        ang_sat = angle;
        if (angle > angle_t'(ANG_LIMIT))
        begin
            ang_sat = angle_t'(ANG_LIMIT);
        end
        else if (angle < -angle_t'(ANG_LIMIT))
        begin
            ang_sat = -angle_t'(ANG_LIMIT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= CORDIC_GAIN;
            y_reg[0] <= '0;
            z_reg[0] <= CW'(ang_sat) <<< Z_SHIFT;
        end
    end

    // one micro-rotation per stage
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i][CW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ATAN_TABLE[i];
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ATAN_TABLE[i];
                end
            end
        end
    end

    if (RSH > 0)
    begin : g_rnd
        assign x_rnd = (x_reg[CORDIC_STEPS] + (CW'(1) <<< (RSH - 1))) >>> RSH;
        assign y_rnd = (y_reg[CORDIC_STEPS] + (CW'(1) <<< (RSH - 1))) >>> RSH;
    end
    else
    begin : g_nornd
        assign x_rnd = x_reg[CORDIC_STEPS];
        assign y_rnd = y_reg[CORDIC_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= ANGLE_WIDTH'(sat_one(x_rnd));
            sin_reg <= ANGLE_WIDTH'(sat_one(y_rnd));
        end
    end

    assign cos_val = cos_reg;
    assign sin_val = sin_reg;

endmodule

@@ rtl/core/eq_merge.sv @@
module eq_merge
    import eq_pkg::*;
#(
    parameter int ANGLE_WIDTH = 16,
    parameter int OUT_WIDTH   = 16
)
(
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [ANGLE_WIDTH-1:0] cy,
    input  logic signed [ANGLE_WIDTH-1:0] sy,
    input  logic signed [ANGLE_WIDTH-1:0] cp,
    input  logic signed [ANGLE_WIDTH-1:0] sp,
    input  logic signed [ANGLE_WIDTH-1:0] cr,
    input  logic signed [ANGLE_WIDTH-1:0] sr,
    output logic signed [OUT_WIDTH-1:0]   quat_w,
    output logic signed [OUT_WIDTH-1:0]   quat_x,
    output logic signed [OUT_WIDTH-1:0]   quat_y,
    output logic signed [OUT_WIDTH-1:0]   quat_z
);

    localparam int AW = ANGLE_WIDTH;
    localparam int PW = 2 * AW;
    localparam int SW = 2 * AW + 1;
    localparam int TF = AW - 2;
    localparam int OF = OUT_WIDTH - 2;
    localparam int RS = 2 * TF - OF;
    localparam int EW = SW + 1 + ((RS < 0) ? -RS : 0);

    // pair order: cr*cp, sr*sp, sr*cp, cr*sp
    logic signed [PW-1:0] pair_reg [4];
    logic signed [AW-1:0] pr_reg   [4];
    logic signed [AW-1:0] cy1_reg, sy1_reg, cy2_reg, sy2_reg;
    // term order: w+, w+, x+, x-, y+, y+, z+, z-
    logic signed [PW-1:0] term_reg [8];
    logic signed [SW-1:0] sum_reg  [4];
    logic signed [OUT_WIDTH-1:0] q_reg [4];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pair_reg[0] <= cr * cp;
            pair_reg[1] <= sr * sp;
            pair_reg[2] <= sr * cp;
            pair_reg[3] <= cr * sp;
            cy1_reg     <= cy;
            sy1_reg     <= sy;
            cy2_reg     <= cy1_reg;
            sy2_reg     <= sy1_reg;
        end
    end

    for (genvar k = 0; k < 4; k++)
    begin : g_pair
        logic signed [PW-1:0] pr_full;
        assign pr_full = (pair_reg[k] + (PW'(1) <<< (TF - 1))) >>> TF;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pr_reg[k] <= AW'(pr_full);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            term_reg[0] <= pr_reg[0] * cy2_reg;
            term_reg[1] <= pr_reg[1] * sy2_reg;
            term_reg[2] <= pr_reg[2] * cy2_reg;
            term_reg[3] <= pr_reg[3] * sy2_reg;
            term_reg[4] <= pr_reg[3] * cy2_reg;
            term_reg[5] <= pr_reg[2] * sy2_reg;
            term_reg[6] <= pr_reg[0] * sy2_reg;
            term_reg[7] <= pr_reg[1] * cy2_reg;

            sum_reg[0]  <= SW'(term_reg[0]) + SW'(term_reg[1]);
            sum_reg[1]  <= SW'(term_reg[2]) - SW'(term_reg[3]);
            sum_reg[2]  <= SW'(term_reg[4]) + SW'(term_reg[5]);
            sum_reg[3]  <= SW'(term_reg[6]) - SW'(term_reg[7]);
        end
    end

    for (genvar k = 0; k < 4; k++)
    begin : g_fin
        logic signed [EW-1:0] r;
        logic signed [EW-1:0] r_sat;
        if (RS > 0)
        begin : g_dn
            assign r = (EW'(sum_reg[k]) + (EW'(1) <<< (RS - 1))) >>> RS;
        end
        else
        begin : g_up
            assign r = EW'(sum_reg[k]) <<< (-RS);
        end
        always_comb
        begin
            r_sat = r;
            if (r > (EW'(1) <<< OF))
            begin
                r_sat = EW'(1) <<< OF;
            end
            else if (r < -(EW'(1) <<< OF))
            begin
                r_sat = -(EW'(1) <<< OF);
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[k] <= OUT_WIDTH'(r_sat);
            end
        end
    end

    assign quat_w = q_reg[0];
    assign quat_x = q_reg[1];
    assign quat_y = q_reg[2];
    assign quat_z = q_reg[3];

endmodule

@@ tb/sv/tb_euler_to_quaternion_core.sv @@
module tb_euler_to_quaternion_core;
    import eq_pkg::*;

    localparam int     OUT_W      = 16;
    localparam int     TRIG_Q     = 14;
    localparam int     LATENCY    = 37;
    localparam int     MAX_CYCLES = 400000;
    localparam longint ANGLE_MAX  = 12868;
    localparam longint GAIN_Q30   = 652032874;

    localparam longint ARCTAN_Q30 [30] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
        131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
        127, 63, 31, 15, 7, 3, 1
    };

    // w in the lowest bits
    typedef struct packed {
        logic signed [OUT_W-1:0] z;
        logic signed [OUT_W-1:0] y;
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] w;
    } quat_t;

    logic                     clk      = 1'b0;
    logic                     rst_n    = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [IN_DATA_W-1:0]     s_tdata  = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [4*OUT_W-1:0]       m_tdata;

    quat_t pending_quats [$];
    quat_t quat_got;
    quat_t quat_want;
    int    fail_count    = 0;
    int    requests_sent = 0;
    int    quats_checked = 0;
    int    clamped_sent  = 0;
    int    cycle_count   = 0;
    bit    source_steady = 1'b0;
    bit    sink_steady   = 1'b0;

    euler_to_quaternion_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic longint sat(input longint v, input longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    function automatic longint rnd_shift(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    // cos and sin of half the Q2.12 angle, Q1.14
    function automatic void half_angle_trig(input angle_t ang, output longint c,
                                            output longint s);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = GAIN_Q30;
        y = 0;
        z = sat(longint'(ang), ANGLE_MAX) * 131072;
        for (int i = 0; i < 30; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - ARCTAN_Q30[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + ARCTAN_Q30[i];
            end
        end
        c = sat(rnd_shift(x, 30 - TRIG_Q), longint'(1) << TRIG_Q);
        s = sat(rnd_shift(y, 30 - TRIG_Q), longint'(1) << TRIG_Q);
    endfunction

    function automatic longint triple(input longint a, input longint b, input longint c);
        return rnd_shift(a * b, TRIG_Q) * c;
    endfunction

    function automatic logic signed [OUT_W-1:0] to_q14(input longint sum);
        longint v;
        v = sat(rnd_shift(sum, TRIG_Q), longint'(1) << (OUT_W - 2));
        return v[OUT_W-1:0];
    endfunction

    function automatic quat_t quat_from_euler(input angle_t yaw, input angle_t pitch,
                                              input angle_t roll);
        longint cy;
        longint sy;
        longint cp;
        longint sp;
        longint cr;
        longint sr;
        quat_t  q;
        half_angle_trig(yaw, cy, sy);
        half_angle_trig(pitch, cp, sp);
        half_angle_trig(roll, cr, sr);
        q.w = to_q14(triple(cr, cp, cy) + triple(sr, sp, sy));
        q.x = to_q14(triple(sr, cp, cy) - triple(cr, sp, sy));
        q.y = to_q14(triple(cr, sp, cy) + triple(sr, cp, sy));
        q.z = to_q14(triple(cr, cp, sy) - triple(sr, sp, cy));
        return q;
    endfunction

    function automatic bit beyond_pi(input angle_t a);
        return (longint'(a) > ANGLE_MAX) || (longint'(a) < -ANGLE_MAX);
    endfunction

    function automatic angle_t rand_angle();
        int pick;
        pick = $urandom_range(99);
        if (pick < 80)
            return angle_t'(int'($urandom_range(2 * 12868)) - 12868);
        if (pick < 88)
            return ($urandom_range(1)) ? angle_t'(12868) : angle_t'(-12868);
        return angle_t'($urandom());
    endfunction

    task automatic send_request(input angle_t yaw, input angle_t pitch, input angle_t roll);
        if (!source_steady)
        begin
            while ($urandom_range(99) < 16)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, roll, pitch, yaw};
        do
            @(posedge clk);
        while (!s_tready);
        pending_quats.push_back(quat_from_euler(yaw, pitch, roll));
        requests_sent++;
        if (beyond_pi(yaw) || beyond_pi(pitch) || beyond_pi(roll))
            clamped_sent++;
    endtask

    task automatic wait_drained();
        while (pending_quats.size() != 0)
            @(posedge clk);
    endtask

    // zero, +-pi, full-scale words, just beyond pi, gimbal lock, tiny angles
    task automatic test_corner_angles();
        send_request(angle_t'(0), angle_t'(0), angle_t'(0));
        send_request(angle_t'(12868), angle_t'(0), angle_t'(0));
        send_request(angle_t'(-12868), angle_t'(0), angle_t'(0));
        send_request(angle_t'(0), angle_t'(12868), angle_t'(0));
        send_request(angle_t'(0), angle_t'(-12868), angle_t'(0));
        send_request(angle_t'(0), angle_t'(0), angle_t'(12868));
        send_request(angle_t'(0), angle_t'(0), angle_t'(-12868));
        send_request(angle_t'(12868), angle_t'(12868), angle_t'(12868));
        send_request(angle_t'(-12868), angle_t'(-12868), angle_t'(-12868));
        send_request(angle_t'(16383), angle_t'(-16384), angle_t'(16383));
        send_request(angle_t'(-16384), angle_t'(16383), angle_t'(-16384));
        send_request(angle_t'(12869), angle_t'(-12869), angle_t'(12869));
        send_request(angle_t'(0), angle_t'(6434), angle_t'(0));
        send_request(angle_t'(3217), angle_t'(6434), angle_t'(-3217));
        send_request(angle_t'(0), angle_t'(-6434), angle_t'(6434));
        send_request(angle_t'(1), angle_t'(-1), angle_t'(1));
        send_request(angle_t'(-1), angle_t'(1), angle_t'(-1));
        send_request(angle_t'(6434), angle_t'(6434), angle_t'(6434));
        send_request(angle_t'(-6434), angle_t'(12868), angle_t'(-12868));
        send_request(angle_t'(12868), angle_t'(-6434), angle_t'(3217));
    endtask

    task automatic test_random_angles(input int count);
        for (int i = 0; i < count; i++)
            send_request(rand_angle(), rand_angle(), rand_angle());
    endtask

    task automatic test_drain_pause();
        test_random_angles(40);
        s_tvalid <= 1'b0;
        wait_drained();
        @(posedge clk);
        test_random_angles(40);
    endtask

    task automatic test_steady_stream(input int count);
        source_steady = 1'b1;
        sink_steady   = 1'b1;
        test_random_angles(count);
        source_steady = 1'b0;
        sink_steady   = 1'b0;
    endtask

    function automatic void check_part(input string name, input logic signed [OUT_W-1:0] want,
                                       input logic signed [OUT_W-1:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        m_tready <= sink_steady || ($urandom_range(99) >= 16);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            quat_got = m_tdata;
            if (pending_quats.size() == 0)
            begin
                $error("unexpected quaternion %h with no request pending", m_tdata);
                fail_count++;
            end
            else
            begin
                quat_want = pending_quats.pop_front();
                check_part("quat_w", quat_want.w, quat_got.w);
                check_part("quat_x", quat_want.x, quat_got.x);
                check_part("quat_y", quat_want.y, quat_got.y);
                check_part("quat_z", quat_want.z, quat_got.z);
                quats_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES)
        begin
            $display("tb_euler_to_quaternion_core NOT OK");
            $finish;
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_corner_angles();
        test_random_angles(300);
        test_drain_pause();
        test_steady_stream(150);
        test_random_angles(200);
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (LATENCY + 20) @(posedge clk);
        $display("%0d angle requests (%0d with angles beyond pi), %0d quaternions checked,",
                 requests_sent, clamped_sent, quats_checked);
        $display("random stalls on both sides, one idle stretch and one full drain");
        if (fail_count == 0 && pending_quats.size() == 0)
            $display("tb_euler_to_quaternion_core OK");
        else
            $display("tb_euler_to_quaternion_core NOT OK");
        $finish;
    end

endmodule
